// ===== rtl/core/bpa_pkg.sv =====
// Package for the buddy page allocator: operation and status codes,
// register indexes and field widths. No dependencies.
package bpa_pkg;

    // Width of a stored block order and of the block_order field.
    localparam int ORD_W = 4;

    // Stream field widths.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int ADDR_W    = 32;

    // Configuration register widths and reset values.
    localparam int BASE_W = 20;
    localparam int CNT_W  = 13;
    localparam logic [BASE_W-1:0] BASE_RST = 20'd65536;
    localparam logic [CNT_W-1:0]  CNT_RST  = 13'd4096;

    // Register index taken from paddr[2].
    localparam logic REG_BASE_FRAME = 1'b0;
    localparam logic REG_PAGE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        FUNC_INIT  = 2'd0,
        FUNC_ALLOC = 2'd1,
        FUNC_FREE  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_NO_BLOCK = 2'd1,
        STAT_BAD_ADDR = 2'd2,
        STAT_NOT_USED = 2'd3
    } t_status;

endpackage

// ===== rtl/core/buddy_page_allocator.sv =====
// Binary buddy page allocator. One transaction takes one operation and gives one result.
// Initialize, allocate and free work through the page order, used and link stores, each with
// one read port and one write port and a registered read. An allocate that finds no block, or
// a free of a bad address, goes straight from idle to the result. A new transaction is taken
// only once the previous one has finished its work, and a finished result waits while an
// earlier one is not yet taken.
module buddy_page_allocator #(
    parameter int ORDER_COUNT = 11,
    parameter int PAGE_BITS   = 12,
    parameter int PAGE_DEPTH  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input: tdata = block_order[3:0], free_address[35:4]; tuser = func[1:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    // Output: tdata = status[1:0], block_address[33:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW  = $clog2(PAGE_DEPTH);
    localparam int LW  = AW + 1;
    localparam int OIW = $clog2(ORDER_COUNT);
    localparam int OW  = bpa_pkg::ORD_W;
    localparam int XW  = ((LW > 16) ? LW : 16) + 1;
    localparam int FW  = 32 - PAGE_BITS;
    localparam int DW  = ((FW > bpa_pkg::BASE_W) ? FW : bpa_pkg::BASE_W) + 1;
    localparam logic [LW-1:0] NIL = LW'(PAGE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT_PAGE, ST_INIT_HEAD, ST_INIT_LINK,
        ST_AL_POP, ST_AL_SPLIT,
        ST_FR_RD, ST_FR_CHK, ST_FR_LOOP, ST_FR_BCHK, ST_FR_MERGE, ST_FR_PUSH,
        ST_UL_RD, ST_UL_W1, ST_UL_W2, ST_PH_W1, ST_PH_W2, ST_DONE
    } t_state;

    t_state r_state, r_ret;

    logic [bpa_pkg::BASE_W-1:0] r_base_frame, r_held_base;
    logic [bpa_pkg::CNT_W-1:0]  r_page_count;
    logic [LW-1:0]              r_held_total;
    logic [LW-1:0]              r_head [ORDER_COUNT];
    logic [LW-1:0]              r_tail [ORDER_COUNT];

    logic [LW-1:0]  r_i, r_blk_end, r_nx;
    logic [AW-1:0]  r_p, r_b;
    logic [OW-1:0]  r_o, r_uo, r_req;
    logic [1:0]     r_status;
    logic [31:0]    r_addr;
    logic           r_mvalid;
    logic [39:0]    r_mdata;

    // Page store ports.
    logic           ord_we, used_we, next_we, prev_we;
    logic [AW-1:0]  ord_wa, used_wa, next_wa, prev_wa;
    logic [AW-1:0]  ord_ra, used_ra, next_ra, prev_ra;
    logic [OW-1:0]  ord_wd, ord_rd;
    logic           used_wd, used_rd;
    logic [LW-1:0]  next_wd, next_rd, prev_wd, prev_rd;

    bpa_ram #(.WIDTH(OW), .DEPTH(PAGE_DEPTH)) u_order (
        .i_clk, .i_we(ord_we), .i_waddr(ord_wa), .i_wdata(ord_wd),
        .i_raddr(ord_ra), .o_rdata(ord_rd));
    bpa_ram #(.WIDTH(1), .DEPTH(PAGE_DEPTH)) u_used (
        .i_clk, .i_we(used_we), .i_waddr(used_wa), .i_wdata(used_wd),
        .i_raddr(used_ra), .o_rdata(used_rd));
    bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_DEPTH)) u_next (
        .i_clk, .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(next_ra), .o_rdata(next_rd));
    bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_DEPTH)) u_prev (
        .i_clk, .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(prev_ra), .o_rdata(prev_rd));

    // Input fields.
    logic [1:0]    in_func;
    logic [OW-1:0] in_order;
    logic [31:0]   in_addr;
    assign in_func  = s_axis_tuser;
    assign in_order = s_axis_tdata[3:0];
    assign in_addr  = s_axis_tdata[35:4];

    // Configuration port.
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == bpa_pkg::REG_PAGE_COUNT)
                  ? {{(32-bpa_pkg::CNT_W){1'b0}}, r_page_count}
                  : {{(32-bpa_pkg::BASE_W){1'b0}}, r_base_frame};

    // Clamp of the page count to the store depth.
    logic [LW-1:0] init_total;
    always_comb begin
        if (XW'(r_page_count) > XW'(PAGE_DEPTH)) begin
            init_total = NIL;
        end else begin
            init_total = LW'(r_page_count);
        end
    end

    // Largest aligned block that starts at page r_i and fits.
    logic [OW-1:0] init_o;
    logic [XW-1:0] init_size, init_sz;
    always_comb begin
        init_o    = '0;
        init_size = XW'(1);
        init_sz   = '0;
        for (int k = 1; k < ORDER_COUNT; k++) begin
            init_sz = XW'(1) << k;
            if (((XW'(r_i) & (init_sz - XW'(1))) == '0) &&
                (XW'(r_i) + init_sz <= XW'(r_held_total))) begin
                init_o    = OW'(k);
                init_size = init_sz;
            end
        end
    end

    // Smallest non-empty list at or above the requested order.
    logic          al_found;
    logic [OW-1:0] al_cur;
    always_comb begin
        al_found = 1'b0;
        al_cur   = '0;
        for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
            if ((OW'(k) >= in_order) && (r_head[k] != NIL)) begin
                al_found = 1'b1;
                al_cur   = OW'(k);
            end
        end
    end

    // Free address checks.
    logic [FW-1:0] fr_pfn;
    logic [DW-1:0] fr_diff;
    logic          fr_bad;
    assign fr_pfn  = in_addr[31:PAGE_BITS];
    assign fr_diff = DW'(fr_pfn) - DW'(r_held_base);
    assign fr_bad  = (in_addr == '0) || (DW'(fr_pfn) < DW'(r_held_base)) ||
                     (fr_diff >= DW'(r_held_total));

    // Working values of the shared address unit.
    logic [OW-1:0] sp_o;
    logic [XW-1:0] sp_b, fr_b;
    logic [AW-1:0] mg_p;
    logic [20:0]   out_frame;
    logic [63:0]   out_shift;
    logic [LW-1:0] uo_head, uo_tail;
    assign sp_o      = r_o - OW'(1);
    assign sp_b      = XW'(r_p) + (XW'(1) << sp_o);
    assign fr_b      = XW'(r_p) ^ (XW'(1) << r_o);
    assign mg_p      = (r_b < r_p) ? r_b : r_p;
    assign out_frame = 21'(r_held_base) + 21'(r_p);
    assign out_shift = 64'(out_frame) << PAGE_BITS;
    assign uo_head   = r_head[r_uo[OIW-1:0]];
    assign uo_tail   = r_tail[r_uo[OIW-1:0]];

    // Page store control.
    always_comb begin
        ord_we  = 1'b0; ord_wa  = r_i[AW-1:0]; ord_wd  = r_o; ord_ra = r_p;
        used_we = 1'b0; used_wa = r_i[AW-1:0]; used_wd = 1'b0; used_ra = r_p;
        next_we = 1'b0; next_wa = r_i[AW-1:0]; next_wd = NIL; next_ra = r_b;
        prev_we = 1'b0; prev_wa = r_i[AW-1:0]; prev_wd = NIL; prev_ra = r_b;
        case (r_state)
            ST_INIT_PAGE: begin
                if (r_i != r_held_total && r_i != r_blk_end) begin
                    ord_we = 1'b1; used_we = 1'b1; next_we = 1'b1; prev_we = 1'b1;
                end
            end
            ST_INIT_HEAD: begin
                ord_we = 1'b1; ord_wd = r_uo;
                used_we = 1'b1; next_we = 1'b1;
                prev_we = 1'b1; prev_wd = uo_tail;
            end
            ST_INIT_LINK: begin
                next_we = 1'b1; next_wa = r_b; next_wd = r_i;
            end
            ST_AL_SPLIT: begin
                if (r_o > r_req) begin
                    if (sp_b < XW'(PAGE_DEPTH)) begin
                        ord_we = 1'b1; ord_wa = sp_b[AW-1:0]; ord_wd = sp_o;
                    end
                end else begin
                    ord_we = 1'b1; ord_wa = r_p; ord_wd = r_req;
                    used_we = 1'b1; used_wa = r_p; used_wd = 1'b1;
                end
            end
            ST_FR_CHK: begin
                if (used_rd) begin
                    used_we = 1'b1; used_wa = r_p; used_wd = 1'b0;
                end
            end
            ST_FR_LOOP: begin
                ord_ra = fr_b[AW-1:0]; used_ra = fr_b[AW-1:0];
            end
            ST_FR_MERGE: begin
                ord_we = 1'b1; ord_wa = mg_p; ord_wd = r_o + OW'(1);
            end
            ST_UL_W1: begin
                if (prev_rd != NIL) begin
                    next_we = 1'b1; next_wa = prev_rd[AW-1:0]; next_wd = next_rd;
                end
                if (next_rd != NIL) begin
                    prev_we = 1'b1; prev_wa = next_rd[AW-1:0]; prev_wd = prev_rd;
                end
            end
            ST_UL_W2: begin
                next_we = 1'b1; next_wa = r_b;
                prev_we = 1'b1; prev_wa = r_b;
            end
            ST_PH_W1: begin
                next_we = 1'b1; next_wa = r_b; next_wd = uo_head;
                prev_we = 1'b1; prev_wa = r_b;
            end
            ST_PH_W2: begin
                prev_we = 1'b1; prev_wa = r_nx[AW-1:0]; prev_wd = LW'(r_b);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= ST_IDLE;
            r_base_frame <= bpa_pkg::BASE_RST;
            r_page_count <= bpa_pkg::CNT_RST;
            r_held_base  <= '0;
            r_held_total <= '0;
            r_mvalid     <= 1'b0;
            for (int k = 0; k < ORDER_COUNT; k++) begin
                r_head[k] <= NIL;
                r_tail[k] <= NIL;
            end
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == bpa_pkg::REG_BASE_FRAME) begin
                    r_base_frame <= pwdata[bpa_pkg::BASE_W-1:0];
                end else begin
                    r_page_count <= pwdata[bpa_pkg::CNT_W-1:0];
                end
            end
            // In ST_DONE the output register is refilled instead.
            if (m_axis_tvalid && m_axis_tready && (r_state != ST_DONE)) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_addr <= '0;
                    if (s_axis_tvalid) begin
                        case (in_func)
                            bpa_pkg::FUNC_INIT: begin
                                r_status     <= bpa_pkg::STAT_DONE;
                                r_held_base  <= r_base_frame;
                                r_held_total <= init_total;
                                r_i          <= '0;
                                r_blk_end    <= '0;
                                for (int k = 0; k < ORDER_COUNT; k++) begin
                                    r_head[k] <= NIL;
                                    r_tail[k] <= NIL;
                                end
                                r_state <= ST_INIT_PAGE;
                            end
                            bpa_pkg::FUNC_ALLOC: begin
                                r_req <= in_order;
                                if ((32'(in_order) >= 32'(ORDER_COUNT)) || !al_found) begin
                                    r_status <= bpa_pkg::STAT_NO_BLOCK;
                                    r_state  <= ST_DONE;
                                end else begin
                                    r_status <= bpa_pkg::STAT_DONE;
                                    r_uo     <= al_cur;
                                    r_o      <= al_cur;
                                    r_state  <= ST_AL_POP;
                                end
                            end
                            bpa_pkg::FUNC_FREE: begin
                                r_p <= fr_diff[AW-1:0];
                                if (fr_bad) begin
                                    r_status <= bpa_pkg::STAT_BAD_ADDR;
                                    r_state  <= ST_DONE;
                                end else begin
                                    r_status <= bpa_pkg::STAT_DONE;
                                    r_state  <= ST_FR_RD;
                                end
                            end
                            default: begin
                                r_status <= bpa_pkg::STAT_DONE;
                                r_state  <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_INIT_PAGE: begin
                    if (r_i == r_held_total) begin
                        r_state <= ST_DONE;
                    end else if (r_i == r_blk_end) begin
                        r_uo      <= init_o;
                        r_blk_end <= r_i + LW'(init_size);
                        r_state   <= ST_INIT_HEAD;
                    end else begin
                        r_i <= r_i + LW'(1);
                    end
                end
                ST_INIT_HEAD: begin
                    r_o <= r_uo;
                    r_tail[r_uo[OIW-1:0]] <= r_i;
                    if (uo_tail != NIL) begin
                        r_b     <= uo_tail[AW-1:0];
                        r_state <= ST_INIT_LINK;
                    end else begin
                        r_head[r_uo[OIW-1:0]] <= r_i;
                        r_i     <= r_i + LW'(1);
                        r_state <= ST_INIT_PAGE;
                    end
                end
                ST_INIT_LINK: begin
                    r_i     <= r_i + LW'(1);
                    r_state <= ST_INIT_PAGE;
                end
                ST_AL_POP: begin
                    r_p     <= uo_head[AW-1:0];
                    r_b     <= uo_head[AW-1:0];
                    r_ret   <= ST_AL_SPLIT;
                    r_state <= ST_UL_RD;
                end
                ST_AL_SPLIT: begin
                    if (r_o > r_req) begin
                        r_o <= sp_o;
                        if (sp_b < XW'(PAGE_DEPTH)) begin
                            r_b     <= sp_b[AW-1:0];
                            r_uo    <= sp_o;
                            r_ret   <= ST_AL_SPLIT;
                            r_state <= ST_PH_W1;
                        end
                    end else begin
                        r_addr  <= out_shift[31:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_FR_RD: begin
                    r_state <= ST_FR_CHK;
                end
                ST_FR_CHK: begin
                    if (!used_rd) begin
                        r_status <= bpa_pkg::STAT_NOT_USED;
                        r_state  <= ST_DONE;
                    end else begin
                        r_o     <= ord_rd;
                        r_state <= ST_FR_LOOP;
                    end
                end
                ST_FR_LOOP: begin
                    if ((32'(r_o) < 32'(ORDER_COUNT - 1)) &&
                        (fr_b < XW'(r_held_total))) begin
                        r_b     <= fr_b[AW-1:0];
                        r_state <= ST_FR_BCHK;
                    end else begin
                        r_state <= ST_FR_PUSH;
                    end
                end
                ST_FR_BCHK: begin
                    if (used_rd || (ord_rd != r_o)) begin
                        r_state <= ST_FR_PUSH;
                    end else begin
                        r_uo    <= r_o;
                        r_ret   <= ST_FR_MERGE;
                        r_state <= ST_UL_RD;
                    end
                end
                ST_FR_MERGE: begin
                    r_p     <= mg_p;
                    r_o     <= r_o + OW'(1);
                    r_state <= ST_FR_LOOP;
                end
                ST_FR_PUSH: begin
                    if (32'(r_o) < 32'(ORDER_COUNT)) begin
                        r_b     <= r_p;
                        r_uo    <= r_o;
                        r_ret   <= ST_DONE;
                        r_state <= ST_PH_W1;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_UL_RD: begin
                    r_state <= ST_UL_W1;
                end
                ST_UL_W1: begin
                    if (prev_rd == NIL) begin
                        r_head[r_uo[OIW-1:0]] <= next_rd;
                    end
                    if (next_rd == NIL) begin
                        r_tail[r_uo[OIW-1:0]] <= prev_rd;
                    end
                    r_state <= ST_UL_W2;
                end
                ST_UL_W2: begin
                    r_state <= r_ret;
                end
                ST_PH_W1: begin
                    r_head[r_uo[OIW-1:0]] <= LW'(r_b);
                    r_nx <= uo_head;
                    if (uo_head != NIL) begin
                        r_state <= ST_PH_W2;
                    end else begin
                        r_tail[r_uo[OIW-1:0]] <= LW'(r_b);
                        r_state <= r_ret;
                    end
                end
                ST_PH_W2: begin
                    r_state <= r_ret;
                end
                ST_DONE: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_mdata  <= {6'b0, r_addr, r_status};
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

endmodule

// ===== rtl/core/bpa_ram.sv =====
// Simple dual-port page store: one write port, one read port, registered read.
// Uses no package items.
module bpa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bpa_checker.sv =====
// Port-level checks for the buddy page allocator, bound to the top level.
// Depends on buddy_page_allocator.
module bpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        pready
);

    // A result that waits is not withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Every failed operation reports a zero address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0) |-> (m_axis_tdata[33:2] == 32'd0))
        else $error("nonzero address with failure status");

    // After a transaction is taken, the input is not ready in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
